// File: sv/sspm_pkg.sv
// ---------------------------------------------------------------------------
// sspm_pkg: shared types and constants of the servo slew / PWM mapper
// Word layouts for both channels, table entry layouts, the action codes,
// the sequencer states and the reset values of the joint tables.
// ---------------------------------------------------------------------------
package sspm_pkg;

    localparam int JOINTS_DEF   = 13;
    localparam int CHANNELS_DEF = 16;

    localparam int ANG_W   = 16;
    localparam int STEP_W  = 15;
    localparam int SPAN_W  = 15;
    localparam int PWM_W   = 12;
    localparam int JOINT_W = 4;
    localparam int CHAN_W  = 4;
    // clamp, invert and offset grow the angle to this width
    localparam int ADJ_W   = 18;
    localparam int DIFF_W  = PWM_W + 1;
    localparam int PROD_W  = DIFF_W + ADJ_W;
    localparam int BASE_W  = PWM_W + SPAN_W;
    localparam int NUM_W   = 32;
    localparam int DIVD_W  = SPAN_W + PWM_W;
    localparam int DIV_CW  = 4;

    localparam logic signed [ANG_W-1:0]  PI_FIX        = 16'sd25736;
    localparam logic [STEP_W-1:0]        STEP_RESET    = 15'd1715;
    localparam logic [PWM_W-1:0]         PWM_MIN_RESET = 12'd100;
    localparam logic [PWM_W-1:0]         PWM_MAX_RESET = 12'd512;
    localparam logic [PWM_W-1:0]         PWM_SAT       = 12'd4095;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_TARGET = 2'd1,
        ACT_CAL    = 2'd2,
        ACT_DRIVE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SLEW,
        S_CLAMP,
        S_MUL,
        S_ADD,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        t_action                    action;
        logic [JOINT_W-1:0]         joint;
        logic signed [ANG_W-1:0]    target_angle;
        logic [STEP_W-1:0]          step_limit;
        logic signed [ANG_W-1:0]    cal_offset;
        logic signed [ANG_W-1:0]    cal_min;
        logic signed [ANG_W-1:0]    cal_max;
        logic                       cal_invert;
        logic [PWM_W-1:0]           cal_pwm_min;
        logic [PWM_W-1:0]           cal_pwm_max;
        logic [SPAN_W-1:0]          cal_span;
        logic [CHAN_W-1:0]          cal_channel;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic [PWM_W-1:0]           pwm_value;
        logic [JOINT_W-1:0]         joint_out;
        logic                       last;
    } t_out_item;

    typedef struct packed {
        logic signed [ANG_W-1:0]    target;
        logic signed [ANG_W-1:0]    current;
    } t_ang_entry;

    typedef struct packed {
        logic signed [ANG_W-1:0]    offset;
        logic signed [ANG_W-1:0]    amin;
        logic signed [ANG_W-1:0]    amax;
        logic                       invert;
        logic [PWM_W-1:0]           pwm_min;
        logic [PWM_W-1:0]           pwm_max;
        logic [SPAN_W-1:0]          span;
        logic [CHAN_W-1:0]          channel;
    } t_cal_entry;

    typedef struct packed {
        logic                       start;
        logic [DIVD_W-1:0]          dividend;
        logic [SPAN_W-1:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic [PWM_W-1:0]           quotient;
    } t_div_rsp;

endpackage

// File: sv/sspm_in_if.sv
// ---------------------------------------------------------------------------
// sspm_in_if: command word channel
// Valid/ready channel carrying one command word to the mapper.
// ---------------------------------------------------------------------------
interface sspm_in_if;
    import sspm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sspm_out_if.sv
// ---------------------------------------------------------------------------
// sspm_out_if: PWM result word channel
// Valid/ready channel carrying one PWM channel/count word.
// ---------------------------------------------------------------------------
interface sspm_out_if;
    import sspm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sspm_div.sv
// ---------------------------------------------------------------------------
// sspm_div: restoring divider for the PWM map
// Divides a dividend known to give a quotient below 4096 by the span,
// one quotient bit per cycle; done pulses with the result.
// ---------------------------------------------------------------------------
module sspm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sspm_pkg::t_div_req i_req,
    output sspm_pkg::t_div_rsp o_rsp
);
    import sspm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] r_div;
    logic [PWM_W-1:0]  r_low;
    logic [PWM_W-1:0]  r_quo;
    logic [SPAN_W-1:0] n_rem;
    logic [SPAN_W:0]   trial;
    logic              take;

    always_comb begin
        trial = {r_rem, r_low[PWM_W-1]};
        take  = trial >= {1'b0, r_div};
        // remainder stays below the divisor, so it fits the span width
        n_rem = take ? SPAN_W'(trial - {1'b0, r_div}) : trial[SPAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(PWM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIVD_W-1:PWM_W];
            r_low <= i_req.dividend[PWM_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[PWM_W-2:0], 1'b0};
            r_quo <= {r_quo[PWM_W-2:0], take};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: sv/servo_slew_pwm_mapper.sv
// ---------------------------------------------------------------------------
// servo_slew_pwm_mapper: slew-rate limiter and PWM mapper for servo joints
// Command words arrive on i_in, PWM words leave on o_out (valid/ready).
// A tick word slews every joint toward its target by at most the shared
// step and sends one word per joint in joint order, last set on the final
// one. A drive word sends one word for its joint; target and calibration
// words send nothing. Words for joints beyond the set are dropped.
// Each joint result passes memory read, slew, clamp, multiply, add and
// range check, then the shared bit-serial divider (twelve quotient bits,
// then the done pulse) and the output register; a count that saturates
// skips the divider. A target word passes memory read and slew only; a
// calibration word is written into its table as it is taken.
// Joint state sits in two single-port tables (angles, calibration) with a
// registered read; per-entry valid bits make unwritten entries read as
// their reset values, so there is no clearing pass after reset.
// A new word is taken while the last result still waits in the output
// register; a stalled receiver holds the sequencer before its next load.
// ---------------------------------------------------------------------------
module servo_slew_pwm_mapper #(
    parameter int JOINTS   = sspm_pkg::JOINTS_DEF,
    parameter int CHANNELS = sspm_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspm_in_if.sink     i_in,
    sspm_out_if.source  o_out
);
    import sspm_pkg::*;

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    logic [JW-1:0]     r_idx;
    logic [STEP_W-1:0] r_step;
    logic [JOINTS-1:0] r_ang_vld;
    logic [JOINTS-1:0] r_cal_vld;

    t_ang_entry        ang_mem [JOINTS];
    t_cal_entry        cal_mem [JOINTS];
    t_ang_entry        r_ang_rd;
    t_cal_entry        r_cal_rd;
    logic              r_ang_rd_vld;
    logic              r_cal_rd_vld;

    logic signed [ANG_W-1:0]  r_ang;
    t_cal_entry               r_cal;
    logic signed [ADJ_W-1:0]  r_adj;
    logic [SPAN_W-1:0]        r_den;
    logic signed [PROD_W-1:0] r_prod;
    logic [BASE_W-1:0]        r_base;
    logic signed [NUM_W-1:0]  r_num;
    logic [PWM_W-1:0]         r_pwm;

    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_fire;
    logic              joint_ok;
    logic [JW-1:0]     in_idx;
    logic              out_free;
    logic              idx_last;
    logic              ang_we;
    logic              out_load;
    logic              num_neg;
    logic              num_ovf;

    t_ang_entry              ang_q;
    t_cal_entry              cal_q;
    t_ang_entry              n_ang_entry;
    logic signed [ANG_W-1:0] n_cur;
    logic signed [ANG_W:0]   slew_d;
    logic [ANG_W:0]          slew_mag;
    logic signed [ANG_W:0]   step_s;
    logic signed [ANG_W-1:0] clamp_a;
    logic signed [ADJ_W-1:0] inv_a;
    logic signed [DIFF_W-1:0] pwm_diff;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    function automatic logic [CHAN_W-1:0] chan_wrap(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << CHAN_W); k++) begin
            if (v == CHAN_W'(k)) begin
                r = CHAN_W'(k % CHANNELS);
            end
        end
        return r;
    endfunction

    function automatic t_cal_entry cal_reset(input logic [JW-1:0] idx);
        t_cal_entry e;
        e.offset  = '0;
        e.amin    = '0;
        e.amax    = PI_FIX;
        e.invert  = 1'b0;
        e.pwm_min = PWM_MIN_RESET;
        e.pwm_max = PWM_MAX_RESET;
        e.span    = SPAN_W'(PI_FIX);
        e.channel = chan_wrap(CHAN_W'(idx));
        return e;
    endfunction

    // ---------------- handshake helpers
    assign in_fire  = i_in.valid && i_in.ready;
    assign joint_ok = {1'b0, i_in.data.joint} < (JOINT_W + 1)'(JOINTS);
    assign in_idx   = i_in.data.joint[JW-1:0];
    assign out_free = !r_out_valid || o_out.ready;
    assign idx_last = r_idx == JW'(JOINTS - 1);

    // ---------------- unwritten entries read as their reset values
    always_comb begin
        ang_q = r_ang_rd_vld ? r_ang_rd : '0;
        cal_q = r_cal_rd_vld ? r_cal_rd : cal_reset(r_idx);
    end

    // ---------------- slew one joint
    always_comb begin
        slew_d   = (ANG_W + 1)'(ang_q.target) - (ANG_W + 1)'(ang_q.current);
        slew_mag = slew_d[ANG_W] ? (ANG_W + 1)'(-slew_d) : (ANG_W + 1)'(slew_d);
        step_s   = $signed({2'b00, r_step});
        if (slew_mag > {2'b00, r_step}) begin
            n_cur = slew_d[ANG_W] ? ANG_W'((ANG_W + 1)'(ang_q.current) - step_s)
                                  : ANG_W'((ANG_W + 1)'(ang_q.current) + step_s);
        end else begin
            n_cur = ang_q.target;
        end
        n_ang_entry.current = (r_item.action == ACT_TICK) ? n_cur : ang_q.current;
        n_ang_entry.target  = (r_item.action == ACT_TICK) ? ang_q.target
                                                          : r_item.target_angle;
    end

    // ---------------- clamp, invert, offset
    always_comb begin
        clamp_a = r_ang;
        // upper bound first, so crossed limits end on the lower one
        if (clamp_a > r_cal.amax) begin
            clamp_a = r_cal.amax;
        end
        if (clamp_a < r_cal.amin) begin
            clamp_a = r_cal.amin;
        end
        inv_a = r_cal.invert ? ADJ_W'(PI_FIX) - ADJ_W'(clamp_a) : ADJ_W'(clamp_a);
        pwm_diff = $signed({1'b0, r_cal.pwm_max}) - $signed({1'b0, r_cal.pwm_min});
    end

    always_comb begin
        num_neg = r_num[NUM_W-1];
        num_ovf = $unsigned(r_num) >= {{(NUM_W - DIVD_W){1'b0}}, r_den, {PWM_W{1'b0}}};
    end

    // ---------------- sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.data.action == ACT_TICK) begin
                        n_state = S_READ;
                    end else if (joint_ok && i_in.data.action != ACT_CAL) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_SLEW;
            S_SLEW:  n_state = (r_item.action == ACT_TARGET) ? S_IDLE : S_CLAMP;
            S_CLAMP: n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_CMP;
            S_CMP:   n_state = (num_neg || num_ovf) ? S_OUT : S_DIV;
            S_DIV:   n_state = div_rsp.done ? S_OUT : S_DIV;
            S_OUT: begin
                if (out_free) begin
                    n_state = (r_item.action == ACT_TICK && !idx_last) ? S_READ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: strobes
    always_comb begin
        i_in.ready       = 1'b0;
        ang_we           = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_num[DIVD_W-1:0];
        div_req.divisor  = r_den;
        unique case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_SLEW:  ang_we = r_item.action != ACT_DRIVE;
            S_CMP:   div_req.start = !num_neg && !num_ovf;
            S_OUT:   out_load = out_free;
            default: ;
        endcase
    end

    // ---------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_step      <= STEP_RESET;
            r_ang_vld   <= '0;
            r_cal_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_idx <= (i_in.data.action == ACT_TICK) ? '0 : in_idx;
                if (joint_ok && i_in.data.action == ACT_TARGET) begin
                    r_step <= i_in.data.step_limit;
                end
                if (joint_ok && i_in.data.action == ACT_CAL) begin
                    r_cal_vld[in_idx] <= 1'b1;
                end
            end
            if (ang_we) begin
                r_ang_vld[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                // advance to the next joint of a tick
                if (!idx_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- joint tables
    always_ff @(posedge i_clk) begin
        if (in_fire && joint_ok && i_in.data.action == ACT_CAL) begin
            cal_mem[in_idx] <= '{offset:  i_in.data.cal_offset,
                                 amin:    i_in.data.cal_min,
                                 amax:    i_in.data.cal_max,
                                 invert:  i_in.data.cal_invert,
                                 pwm_min: i_in.data.cal_pwm_min,
                                 pwm_max: i_in.data.cal_pwm_max,
                                 span:    i_in.data.cal_span,
                                 channel: chan_wrap(i_in.data.cal_channel)};
        end
        if (r_state == S_READ) begin
            r_cal_rd     <= cal_mem[r_idx];
            r_cal_rd_vld <= r_cal_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ang_we) begin
            ang_mem[r_idx] <= n_ang_entry;
        end
        if (r_state == S_READ) begin
            r_ang_rd     <= ang_mem[r_idx];
            r_ang_rd_vld <= r_ang_vld[r_idx];
        end
    end

    // ---------------- datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in.data;
        end
        unique case (r_state)
            S_SLEW: begin
                r_ang <= (r_item.action == ACT_TICK) ? n_cur : r_item.target_angle;
                r_cal <= cal_q;
            end
            S_CLAMP: begin
                r_adj <= inv_a + ADJ_W'(r_cal.offset);
                r_den <= (r_cal.span == '0) ? SPAN_W'(1) : r_cal.span;
            end
            S_MUL: begin
                r_prod <= PROD_W'(pwm_diff * r_adj);
                r_base <= BASE_W'(r_cal.pwm_min * r_den);
            end
            S_ADD: begin
                r_num <= NUM_W'(r_prod) + $signed({{(NUM_W - BASE_W){1'b0}}, r_base});
            end
            S_CMP: begin
                // negative numerators truncate to zero or below: saturate low
                r_pwm <= num_neg ? '0 : PWM_SAT;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    r_pwm <= div_rsp.quotient;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.channel   <= r_cal.channel;
            r_out.pwm_value <= r_pwm;
            r_out.joint_out <= JOINT_W'(r_idx);
            r_out.last      <= (r_item.action != ACT_TICK) || idx_last;
        end
    end

    sspm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
